[sv/ordered_list_stack_engine_macros.svh]
// Assertion macros for the ordered list stack engine.
// Taken in by the controller and the datapath; needs nothing else.
`ifndef ORDERED_LIST_STACK_ENGINE_MACROS_SVH
`define ORDERED_LIST_STACK_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OLSE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OLSE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/olse_pkg.sv]
// Shared types and codes for the ordered list stack engine.
// No dependencies; imported by the top, controller and datapath modules.
package olse_pkg;

	// Command codes
	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_FIND   = 3'd2;
	localparam logic [2:0] CMD_INSERT = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;
	localparam logic [2:0] CMD_QUERY  = 3'd6;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NOKEY = 2'd3;

	// Popped value when nothing is popped
	localparam logic signed [31:0] POP_NONE = -32'sd1;

	// Scan pointer operations
	localparam logic [2:0] PTR_HOLD     = 3'd0;
	localparam logic [2:0] PTR_TOP      = 3'd1;
	localparam logic [2:0] PTR_AFTER_RD = 3'd2;
	localparam logic [2:0] PTR_DEC      = 3'd3;
	localparam logic [2:0] PTR_INC      = 3'd4;

	// Store write selections
	localparam logic [2:0] WR_NONE = 3'd0;
	localparam logic [2:0] WR_PUSH = 3'd1;
	localparam logic [2:0] WR_UP   = 3'd2;
	localparam logic [2:0] WR_DOWN = 3'd3;
	localparam logic [2:0] WR_PUT  = 3'd4;

	// Entry count operations
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
		logic signed [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] popped;
		logic               found;
		logic               is_empty;
		logic [1:0]         status;
		logic [4:0]         length;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [2:0] ptr_op;
		logic [2:0] wr_sel;
		logic       hit_capture;
		logic [1:0] cnt_op;
		logic       finish;
		logic [1:0] fin_status;
		logic       fin_found;
		logic       fin_pop;
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       empty;
		logic       full;
		logic       rd_vld;
		logic       hit;
		logic       rd_at_zero;
		logic       rd_at_hit;
		logic       rd_at_last;
		logic       ptr_at_zero;
		logic       ptr_at_hit;
		logic       ptr_at_last;
	} dp_stat_t;

endpackage

[sv/ordered_list_stack_engine.sv]
// Ordered list stack engine: keeps an ordered list of up to DEPTH signed 32-bit values.
// Usage: drive item (command, value, key) and raise start; the transaction is taken at
// a rising edge with start high and busy low. Busy stays high until the result is out.
// Each transaction gives one result on result, marked by done for one cycle; the
// receiver cannot hold it off and must take it in that cycle.
// Find, insert and remove walk the store one entry a cycle through the single read
// port of the entry memory, so the list length sets their latency. The next
// transaction is taken in the cycle in which done is high.
// Reset (arst_n low) empties the list; the entry memory is not cleared, as only
// entries below the count are ever read.
// Depends on olse_pkg, olse_ctrl, olse_dpath and olse_ram.
module ordered_list_stack_engine #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  olse_pkg::in_item_t  item,
	output logic                done,
	output olse_pkg::out_item_t result
);
	import olse_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// Sequencer
	olse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	// Store, count and result
	olse_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule

[sv/olse_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module olse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/olse_dpath.sv]
// Datapath of the ordered list stack engine: entry store, count, scan pointer, result.
// Depends on olse_pkg, olse_ram and the assertion macro header.
`include "ordered_list_stack_engine_macros.svh"

module olse_dpath #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  olse_pkg::in_item_t item,
	input  olse_pkg::dp_ctl_t  ctl,
	output olse_pkg::dp_stat_t stat,
	output olse_pkg::out_item_t result,
	output logic               done
);
	import olse_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// The store keeps the top of the list at the highest used address.
	in_item_t        item_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CW-1:0]   count_m1;
	logic [AW-1:0]   top_addr;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   ptr_d;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_addr_s1;
	logic [AW-1:0]   rd_after;
	logic [AW-1:0]   hit_q;
	logic [31:0]     rdata;
	logic [31:0]     skey;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [31:0]     wdata;
	out_item_t       result_q;
	logic            done_q;

	assign count_m1 = count_q - CW'(1);
	assign top_addr = count_m1[AW-1:0];
	assign rd_after = rd_addr_s1 + AW'(1);

	// Insert searches by key, find and remove by value
	assign skey = (item_q.command == CMD_INSERT) ? item_q.key : item_q.value;

	// Status towards the controller
	assign stat.cmd         = item_q.command;
	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q == CW'(DEPTH));
	assign stat.rd_vld      = rd_vld_s1;
	assign stat.hit         = rd_vld_s1 && (rdata == skey);
	assign stat.rd_at_zero  = (rd_addr_s1 == '0);
	assign stat.rd_at_hit   = (rd_addr_s1 == hit_q);
	assign stat.rd_at_last  = (rd_addr_s1 == top_addr);
	assign stat.ptr_at_zero = (ptr_q == '0);
	assign stat.ptr_at_hit  = (ptr_q == hit_q);
	assign stat.ptr_at_last = (ptr_q == top_addr);

	// Advance the scan pointer
	always_comb begin
		ptr_d = ptr_q;
		unique case (ctl.ptr_op)
			PTR_HOLD:     ptr_d = ptr_q;
			PTR_TOP:      ptr_d = top_addr;
			PTR_AFTER_RD: ptr_d = rd_after;
			PTR_DEC:      ptr_d = ptr_q - AW'(1);
			PTR_INC:      ptr_d = ptr_q + AW'(1);
			default:      ptr_d = ptr_q;
		endcase
	end

	// Select the store write
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = item_q.value;
		unique case (ctl.wr_sel)
			WR_NONE: we = 1'b0;
			WR_PUSH: begin
				we    = 1'b1;
				waddr = count_q[AW-1:0];
				wdata = item_q.value;
			end
			WR_UP: begin
				we    = 1'b1;
				waddr = rd_after;
				wdata = rdata;
			end
			WR_DOWN: begin
				we    = 1'b1;
				waddr = rd_addr_s1 - AW'(1);
				wdata = rdata;
			end
			WR_PUT: begin
				we    = 1'b1;
				waddr = hit_q;
				wdata = item_q.value;
			end
			default: we = 1'b0;
		endcase
	end

	// Update the entry count
	always_comb begin
		unique case (ctl.cnt_op)
			CNT_HOLD: count_d = count_q;
			CNT_INC:  count_d = count_q + CW'(1);
			CNT_DEC:  count_d = count_m1;
			CNT_CLR:  count_d = '0;
		endcase
	end

	olse_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			count_q   <= count_d;
			rd_vld_s1 <= ctl.rd_en;
			done_q    <= ctl.finish;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
		ptr_q      <= ptr_d;
		rd_addr_s1 <= ptr_q;
		if (ctl.hit_capture) begin
			hit_q <= rd_addr_s1;
		end
		if (ctl.finish) begin
			result_q.popped   <= ctl.fin_pop ? $signed(rdata) : POP_NONE;
			result_q.found    <= ctl.fin_found;
			result_q.is_empty <= (count_d == '0);
			result_q.status   <= ctl.fin_status;
			result_q.length   <= 5'(count_d);
		end
	end

	assign result = result_q;
	assign done   = done_q;

	`OLSE_ASSERT_IMPL(a_inc_not_full, clk, arst_n, ctl.cnt_op == CNT_INC, count_q < CW'(DEPTH), "grow full")
	`OLSE_ASSERT_IMPL(a_dec_not_empty, clk, arst_n, ctl.cnt_op == CNT_DEC, count_q != '0, "shrink empty")
	`OLSE_ASSERT_IMPL(a_move_has_data, clk, arst_n, ctl.wr_sel == WR_UP || ctl.wr_sel == WR_DOWN, rd_vld_s1, "move no data")

endmodule

[sv/olse_ctrl.sv]
// Controller of the ordered list stack engine: sequences scans, shifts and results.
// Depends on olse_pkg and the assertion macro header.
`include "ordered_list_stack_engine_macros.svh"

module olse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  olse_pkg::dp_stat_t stat,
	output olse_pkg::dp_ctl_t  ctl
);
	import olse_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DECODE    = 3'd1;
	localparam logic [2:0] S_SCAN      = 3'd2;
	localparam logic [2:0] S_INS_SHIFT = 3'd3;
	localparam logic [2:0] S_INS_PUT   = 3'd4;
	localparam logic [2:0] S_REM_SHIFT = 3'd5;
	localparam logic [2:0] S_POP_RD    = 3'd6;
	localparam logic [2:0] S_POP_WAIT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and datapath commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_PUSH: begin
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.full) begin
							ctl.fin_status = ST_FULL;
						end else begin
							ctl.wr_sel = WR_PUSH;
							ctl.cnt_op = CNT_INC;
						end
					end
					CMD_POP: begin
						if (stat.empty) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ST_EMPTY;
							state_d        = S_IDLE;
						end else begin
							ctl.ptr_op = PTR_TOP;
							state_d    = S_POP_RD;
						end
					end
					CMD_FIND, CMD_REMOVE: begin
						if (stat.empty) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ST_NOKEY;
							state_d        = S_IDLE;
						end else begin
							ctl.ptr_op = PTR_TOP;
							state_d    = S_SCAN;
						end
					end
					CMD_INSERT: begin
						priority if (stat.full) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ST_FULL;
							state_d        = S_IDLE;
						end else if (stat.empty) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ST_NOKEY;
							state_d        = S_IDLE;
						end else begin
							ctl.ptr_op = PTR_TOP;
							state_d    = S_SCAN;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_op = CNT_CLR;
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
					CMD_QUERY: begin
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
					default: begin
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			// Walk from the top towards the bottom, one read a cycle
			S_SCAN: begin
				priority if (stat.hit) begin
					ctl.rd_en  = 1'b0;
					ctl.ptr_op = PTR_HOLD;
					priority if (stat.cmd == CMD_FIND) begin
						ctl.finish    = 1'b1;
						ctl.fin_found = 1'b1;
						state_d       = S_IDLE;
					end else if (stat.cmd == CMD_INSERT) begin
						ctl.hit_capture = 1'b1;
						ctl.ptr_op      = PTR_TOP;
						state_d         = S_INS_SHIFT;
					end else if (stat.rd_at_last) begin
						ctl.cnt_op = CNT_DEC;
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end else begin
						ctl.ptr_op = PTR_AFTER_RD;
						state_d    = S_REM_SHIFT;
					end
				end else if (stat.rd_vld && stat.rd_at_zero) begin
					ctl.rd_en      = 1'b0;
					ctl.finish     = 1'b1;
					ctl.fin_status = ST_NOKEY;
					state_d        = S_IDLE;
				end else begin
					// Keep reading; hold at the bottom entry
					ctl.rd_en  = 1'b1;
					ctl.ptr_op = stat.ptr_at_zero ? PTR_HOLD : PTR_DEC;
				end
			end
			// Move entries from the top down to the match one place up
			S_INS_SHIFT: begin
				ctl.rd_en  = 1'b1;
				ctl.ptr_op = stat.ptr_at_hit ? PTR_HOLD : PTR_DEC;
				if (stat.rd_vld) begin
					ctl.wr_sel = WR_UP;
					if (stat.rd_at_hit) begin
						ctl.rd_en = 1'b0;
						state_d   = S_INS_PUT;
					end
				end
			end
			S_INS_PUT: begin
				ctl.wr_sel = WR_PUT;
				ctl.cnt_op = CNT_INC;
				ctl.finish = 1'b1;
				state_d    = S_IDLE;
			end
			// Close the gap: move entries above the match one place down
			S_REM_SHIFT: begin
				ctl.rd_en  = 1'b1;
				ctl.ptr_op = stat.ptr_at_last ? PTR_HOLD : PTR_INC;
				if (stat.rd_vld) begin
					ctl.wr_sel = WR_DOWN;
					if (stat.rd_at_last) begin
						ctl.rd_en  = 1'b0;
						ctl.cnt_op = CNT_DEC;
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_POP_RD: begin
				ctl.rd_en = 1'b1;
				state_d   = S_POP_WAIT;
			end
			S_POP_WAIT: begin
				ctl.fin_pop = 1'b1;
				ctl.cnt_op  = CNT_DEC;
				ctl.finish  = 1'b1;
				state_d     = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`OLSE_ASSERT_NEXT(a_finish_idle, clk, arst_n, ctl.finish, state_q == S_IDLE, "no idle after result")
	`OLSE_ASSERT_NEXT(a_accept_decode, clk, arst_n, start && !busy, state_q == S_DECODE, "accept lost")
	`OLSE_ASSERT_IMPL(a_finish_busy, clk, arst_n, ctl.finish, busy, "result while idle")

endmodule
